/* hdl/uts_pkg.sv */
`timescale 1ns / 1ps

package uts_pkg;

	localparam int TsW     = 64;
	localparam int BorrowW = 32;
	localparam int SeqW    = 16;
	localparam int NodeW   = 8;
	localparam int MacW    = 48;
	localparam int CfgIdxW = 1;

	localparam logic [CfgIdxW-1:0] REG_NODE_ID     = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_MAC_ADDRESS = 1'b1;

	localparam logic [NodeW-1:0] NODE_ID_RST     = '0;
	localparam logic [MacW-1:0]  MAC_ADDRESS_RST = '0;

	typedef struct packed {
		logic [TsW-1:0]  now_ticks;
		logic            txn_valid;
		logic [TsW-1:0]  txn_id;
		logic [SeqW-1:0] random_seq;
	} uts_item_t;

	typedef struct packed {
		logic [TsW-1:0]     last_time;
		logic [BorrowW-1:0] borrow_count;
		logic [SeqW-1:0]    clock_seq;
	} uts_state_t;

endpackage

/* hdl/uts_req_if.sv */
`timescale 1ns / 1ps

interface uts_req_if;
	logic                     valid;
	logic                     ready;
	logic [uts_pkg::TsW-1:0]  now_ticks;
	logic                     txn_valid;
	logic [uts_pkg::TsW-1:0]  txn_id;
	logic [uts_pkg::SeqW-1:0] random_seq;

	modport source (output valid, now_ticks, txn_valid, txn_id, random_seq, input ready);
	modport sink (input valid, now_ticks, txn_valid, txn_id, random_seq, output ready);
endinterface

/* hdl/uts_rsp_if.sv */
`timescale 1ns / 1ps

interface uts_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [uts_pkg::TsW-1:0]   timestamp;
	logic [31:0]               time_low;
	logic [15:0]               time_mid;
	logic [15:0]               time_high_node;
	logic [uts_pkg::SeqW-1:0]  clock_sequence;
	logic [uts_pkg::MacW-1:0]  node_address;
	logic                      reseeded;

	modport source (output valid, timestamp, time_low, time_mid, time_high_node,
		clock_sequence, node_address, reseeded, input ready);
	modport sink (input valid, timestamp, time_low, time_mid, time_high_node,
		clock_sequence, node_address, reseeded, output ready);
endinterface

/* hdl/uts_cfg_if.sv */
`timescale 1ns / 1ps

interface uts_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [uts_pkg::CfgIdxW-1:0] index;
	logic [uts_pkg::MacW-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/uts_calc.sv */
`timescale 1ns / 1ps

module uts_calc (
	input  uts_pkg::uts_item_t  item,
	input  uts_pkg::uts_state_t cur,
	output uts_pkg::uts_state_t nxt,
	output logic                reseeded
);

	localparam int TsW = uts_pkg::TsW;
	localparam int BW  = uts_pkg::BorrowW;

	logic [TsW-1:0] cand0, cand1, cand2, cand3, room, last_p1;
	logic [TsW:0]   txn_sum;
	logic [BW-1:0]  borrow2, borrow3;
	logic           give, room_lt, tie, backward, first;

	always_comb begin
		first   = (cur.last_time == '0);
		cand0   = item.now_ticks + {{(TsW-BW){1'b0}}, cur.borrow_count};
		txn_sum = {1'b0, cand0} + {1'b0, item.txn_id};
		cand1   = (item.txn_valid && !txn_sum[TsW]) ? txn_sum[TsW-1:0] : cand0;

		// return borrowed ticks, never dropping below last+1
		last_p1 = cur.last_time + {{(TsW-1){1'b0}}, 1'b1};
		room    = cand1 - last_p1;
		give    = (cand1 > cur.last_time) && (cur.borrow_count != '0);
		room_lt = room < {{(TsW-BW){1'b0}}, cur.borrow_count};
		if (give) begin
			if (room_lt) begin
				cand2   = last_p1;
				borrow2 = cur.borrow_count - room[BW-1:0];
			end else begin
				cand2   = cand1 - {{(TsW-BW){1'b0}}, cur.borrow_count};
				borrow2 = '0;
			end
		end else begin
			cand2   = cand1;
			borrow2 = cur.borrow_count;
		end

		tie     = (cand2 == cur.last_time);
		borrow3 = tie ? borrow2 + {{(BW-1){1'b0}}, 1'b1} : borrow2;
		cand3   = (tie && borrow3 != '0) ? cand2 + {{(TsW-1){1'b0}}, 1'b1} : cand2;

		backward = (cand3 <= cur.last_time);

		nxt.last_time    = backward ? item.now_ticks : cand3;
		nxt.borrow_count = backward ? '0 : borrow3;
		nxt.clock_seq    = (first || backward) ? item.random_seq : cur.clock_seq;
		reseeded         = first || backward;
	end

endmodule

/* hdl/uuid_timestamp_sequencer.sv */
`timescale 1ns / 1ps

// UUID v1 timestamp sequencer. Each request word carries the current time in 100 ns
// ticks, an optional transaction id and a random value; each yields one result word
// with a strictly increasing timestamp (unless the clock sequence reseeds), the split
// uuid time fields, the clock sequence and the configured node address. Requests are
// registered, evaluated combinationally against the sequencer state, and the result is
// held in an output register, so one request is taken per cycle while the output
// register is empty or its result is being taken; a stalled result holds off requests.
// Configuration writes (index 0 node_id, index 1 mac_address) are always ready and
// are meant to happen while no request is in flight.

module uuid_timestamp_sequencer (
	input  logic     clk,
	input  logic     arst_n,
	uts_req_if.sink  req,
	uts_rsp_if.source rsp,
	uts_cfg_if.sink  cfg
);

	localparam int NodeW = uts_pkg::NodeW;
	localparam int MacW  = uts_pkg::MacW;

	uts_pkg::uts_item_t  item_s1;
	logic                valid_s1;
	uts_pkg::uts_state_t state_q, state_nxt;
	logic                reseed_nxt;

	logic [uts_pkg::TsW-1:0]  ts_s2;
	logic [uts_pkg::SeqW-1:0] seq_s2;
	logic                     reseed_s2;
	logic                     valid_s2;

	logic [NodeW-1:0] node_id_q;
	logic [MacW-1:0]  mac_q;

	logic advance, s1_fire, req_fire;

	assign advance   = !valid_s2 || rsp.ready;
	assign s1_fire   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	uts_calc u_calc (
		.item     (item_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.reseeded (reseed_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance)
				valid_s2 <= valid_s1;
			if (s1_fire)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= uts_pkg::NODE_ID_RST;
			mac_q     <= uts_pkg::MAC_ADDRESS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				uts_pkg::REG_NODE_ID:     node_id_q <= cfg.data[NodeW-1:0];
				uts_pkg::REG_MAC_ADDRESS: mac_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1.now_ticks  <= req.now_ticks;
			item_s1.txn_valid  <= req.txn_valid;
			item_s1.txn_id     <= req.txn_id;
			item_s1.random_seq <= req.random_seq;
		end
		if (s1_fire) begin
			ts_s2     <= state_nxt.last_time;
			seq_s2    <= state_nxt.clock_seq;
			reseed_s2 <= reseed_nxt;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.timestamp      = ts_s2;
	assign rsp.time_low       = ts_s2[31:0];
	assign rsp.time_mid       = ts_s2[47:32];
	assign rsp.time_high_node = ts_s2[63:48] | {node_id_q, 8'h00};
	assign rsp.clock_sequence = seq_s2;
	assign rsp.node_address   = mac_q;
	assign rsp.reseeded       = reseed_s2;

	// held result always matches the committed last time
	a_ts_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ts_s2 == state_q.last_time)
		else $error("result timestamp differs from last time");

	// without a reseed the timestamp strictly increases
	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !reseed_nxt |=> state_q.last_time > $past(state_q.last_time))
		else $error("timestamp did not increase");

	// a stalled result freezes the sequencer state
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rsp.ready |=> $stable(state_q))
		else $error("state moved while result stalled");

	// a backward-time reseed leaves no borrowed ticks
	a_reseed_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && reseed_nxt && state_q.last_time != '0 |=> state_q.borrow_count == '0)
		else $error("borrow count survived reseed");

endmodule

/* dv/uts_stamp_checker.sv */
`timescale 1ns / 1ps

module uts_stamp_checker
	import uts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	uts_req_if          req,
	uts_rsp_if          rsp,
	uts_cfg_if          cfg,
	output int unsigned errors,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned reseeds
);

	typedef struct packed {
		logic [TsW-1:0]  timestamp;
		logic [31:0]     time_low;
		logic [15:0]     time_mid;
		logic [15:0]     time_high_node;
		logic [SeqW-1:0] clock_sequence;
		logic [MacW-1:0] node_address;
		logic            reseeded;
	} stamp_t;

	logic [NodeW-1:0]   node_cfg;
	logic [MacW-1:0]    mac_cfg;
	logic [TsW-1:0]     last_ts;
	logic [BorrowW-1:0] borrow;
	logic [SeqW-1:0]    seq;
	stamp_t             stamp_q[$];

	task automatic next_stamp(input uts_item_t it, output stamp_t s);
		logic [TsW:0]       sum;
		logic [TsW-1:0]     cand;
		logic [TsW-1:0]     room;
		logic [BorrowW-1:0] back;
		logic               fresh;
		fresh = 1'b0;
		if (last_ts == '0) begin
			seq = it.random_seq;
			fresh = 1'b1;
		end
		cand = it.now_ticks + {32'd0, borrow};
		if (it.txn_valid) begin
			sum = {1'b0, cand} + {1'b0, it.txn_id};
			if (!sum[TsW])
				cand = sum[TsW-1:0];
		end
		// hand back borrowed ticks, never dropping to last_ts or below
		if (cand > last_ts && borrow != '0) begin
			room = cand - last_ts - 64'd1;
			back = (room < {32'd0, borrow}) ? room[BorrowW-1:0] : borrow;
			cand = cand - {32'd0, back};
			borrow = borrow - back;
		end
		if (cand == last_ts) begin
			borrow = borrow + 32'd1;
			if (borrow != '0)
				cand = cand + 64'd1;
		end
		if (cand <= last_ts) begin
			seq = it.random_seq;
			fresh = 1'b1;
			cand = it.now_ticks;
			borrow = '0;
		end
		last_ts = cand;
		s.timestamp = cand;
		s.time_low = cand[31:0];
		s.time_mid = cand[47:32];
		s.time_high_node = cand[63:48] | {node_cfg, 8'h00};
		s.clock_sequence = seq;
		s.node_address = mac_cfg;
		s.reseeded = fresh;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			if (errors < 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stamp_t    want;
		uts_item_t it;
		if (!arst_n) begin
			node_cfg = NODE_ID_RST;
			mac_cfg = MAC_ADDRESS_RST;
			last_ts = '0;
			borrow = '0;
			seq = '0;
			stamp_q.delete();
			errors = 0;
			checked = 0;
			reseeds = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_NODE_ID: node_cfg = cfg.data[NodeW-1:0];
					REG_MAC_ADDRESS: mac_cfg = cfg.data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (stamp_q.size() == 0) begin
					if (errors < 10)
						$display("result word with no request pending: ts %h", rsp.timestamp);
					errors++;
				end else begin
					want = stamp_q.pop_front();
					check_field("timestamp", want.timestamp, rsp.timestamp);
					check_field("time_low", {32'd0, want.time_low}, {32'd0, rsp.time_low});
					check_field("time_mid", {48'd0, want.time_mid}, {48'd0, rsp.time_mid});
					check_field("time_high_node", {48'd0, want.time_high_node},
						{48'd0, rsp.time_high_node});
					check_field("clock_sequence", {48'd0, want.clock_sequence},
						{48'd0, rsp.clock_sequence});
					check_field("node_address", {16'd0, want.node_address},
						{16'd0, rsp.node_address});
					check_field("reseeded", {63'd0, want.reseeded}, {63'd0, rsp.reseeded});
					checked++;
					if (want.reseeded)
						reseeds++;
				end
			end
			if (req.valid && req.ready) begin
				it.now_ticks = req.now_ticks;
				it.txn_valid = req.txn_valid;
				it.txn_id = req.txn_id;
				it.random_seq = req.random_seq;
				next_stamp(it, want);
				stamp_q.push_back(want);
			end
			pending <= stamp_q.size();
		end
	end

endmodule

/* dv/uuid_timestamp_sequencer_test.sv */
`timescale 1ns / 1ps

module uuid_timestamp_sequencer_test;
	import uts_pkg::*;

	localparam int StallLimit = 5000;
	localparam logic [63:0] TsMax = 64'hFFFF_FFFF_FFFF_FFFF;

	logic        clk;
	logic        arst_n;
	int unsigned errors;
	int unsigned pending;
	int unsigned checked;
	int unsigned reseeds;
	int unsigned idle_pct;
	int unsigned settings;
	logic [63:0] wall;

	uts_req_if req_ch();
	uts_rsp_if rsp_ch();
	uts_cfg_if cfg_ch();

	uuid_timestamp_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	uts_stamp_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked),
		.reseeds (reseeds)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MacW-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [NodeW-1:0] node, input logic [MacW-1:0] mac);
		write_reg(REG_NODE_ID, {40'd0, node});
		write_reg(REG_MAC_ADDRESS, mac);
		cfg_ch.valid <= 1'b0;
		settings++;
	endtask

	task automatic send_req(input logic [63:0] now, input logic tv, input logic [63:0] tid,
		input logic [15:0] rnd);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.now_ticks <= now;
		req_ch.txn_valid <= tv;
		req_ch.txn_id <= tid;
		req_ch.random_seq <= rnd;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// hold off until every outstanding word is back, then let the pipe settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_req();
		int unsigned pick;
		logic        tv;
		logic [63:0] tid;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			wall = wall + 64'($urandom_range(0, 2));
		else if (pick < 60)
			wall = wall + 64'($urandom_range(0, 40));
		else if (pick < 70)
			wall = wall + 64'($urandom_range(0, 1000));
		else if (pick < 78)
			wall = wall - 64'($urandom_range(1, 50));
		else if (pick < 84)
			wall = {$urandom, $urandom};
		else if (pick < 90)
			wall = TsMax - 64'($urandom_range(0, 20));
		else if (pick < 94)
			wall = 64'($urandom_range(0, 3));
		else
			wall = wall + {32'd0, $urandom};
		tv = ($urandom_range(0, 99) < 25);
		pick = $urandom_range(0, 99);
		if (pick < 40)
			tid = 64'($urandom_range(0, 8));
		else if (pick < 70)
			tid = {$urandom, $urandom};
		else
			tid = {32'hFFFF_FFFF, $urandom};
		send_req(wall, tv, tid, 16'($urandom_range(0, 65535)));
	endtask

	initial begin
		int unsigned stall;
		stall = 0;
		while (stall < StallLimit) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				stall = 0;
			else
				stall++;
		end
		$display("watchdog: no handshake for %0d cycles", StallLimit);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.now_ticks <= '0;
		req_ch.txn_valid <= 1'b0;
		req_ch.txn_id <= '0;
		req_ch.random_seq <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_NODE_ID;
		cfg_ch.data <= '0;
		idle_pct = 35;
		settings = 0;
		wall = 64'd5000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(8'hFF, 48'hFFFF_FFFF_FFFF);
		send_req(64'd1000, 1'b0, 64'd0, 16'h0000);
		send_req(64'd1000, 1'b0, TsMax, 16'hFFFF);
		send_req(64'd1000, 1'b0, 64'd0, 16'h1234);
		send_req(64'd1001, 1'b0, 64'd0, 16'h4321);
		send_req(64'd1010, 1'b0, 64'd0, 16'h0001);
		send_req(64'd2000, 1'b1, 64'd5, 16'h0002);
		send_req(64'd100, 1'b0, 64'd0, 16'hBEEF);
		send_req(64'd0, 1'b0, 64'd0, 16'hCAFE);
		send_req(64'd0, 1'b0, 64'd0, 16'h8000);
		send_req(64'd0, 1'b0, 64'd0, 16'h7FFF);
		send_req(TsMax, 1'b1, TsMax, 16'hFFFF);
		send_req(TsMax, 1'b0, 64'd0, 16'h0000);
		send_req(TsMax - 64'd10, 1'b1, 64'd5, 16'h00FF);
		send_req(64'h8000_0000_0000_0000, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 16'hFF00);
		send_req(64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000, 16'h0F0F);
		send_req(64'h5555_5555_5555_5555, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
		send_req(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h5555_5555_5555_5555, 16'hAAAA);

		for (int ph = 1; ph <= 5; ph++) begin
			drain();
			case (ph)
				1: configure(8'h00, 48'h0);
				3: configure(8'hFF, 48'h0);
				4: configure(8'h00, 48'hFFFF_FFFF_FFFF);
				default: configure(8'($urandom_range(0, 255)), {16'($urandom), $urandom});
			endcase
			idle_pct = (ph == 2) ? 0 : 35;
			repeat (350) random_req();
		end
		drain();

		$display("Checked %0d timestamps (%0d with a clock sequence reload) over %0d",
			checked, reseeds, settings);
		$display("node/address settings, with ties, borrow give-back, wrap and backward time.");
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
